### rtl/core/ccu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_pkg: shared types and constants for the combinatorial count unit
// Request and response beat layouts, command and status codes, and the
// default sizing of the count datapath.
// ----------------------------------------------------------------------------
package ccu_pkg;

	localparam int OPND_W           = 8;
	localparam int FAC_W            = OPND_W + 1;
	localparam int COUNT_W          = 64;
	localparam int MAX_N_DEF        = 255;
	localparam int RESULT_WIDTH_DEF = 64;

	localparam logic [2:0] CMD_POWER     = 3'd0;
	localparam logic [2:0] CMD_ARRANGE   = 3'd1;
	localparam logic [2:0] CMD_MULTISET  = 3'd2;
	localparam logic [2:0] CMD_COMBINE   = 3'd3;
	localparam logic [2:0] CMD_FACTORIAL = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [OPND_W-1:0] set_size;
		logic [OPND_W-1:0] pick_count;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
	} rsp_t;

endpackage

### rtl/core/combinatorial_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combinatorial_count_unit: exact counts of powers, arrangements and choices
// Computes n^k, n!/(n-k)!, C(n+k-1,k), C(n,k) or n! with one shared
// multiplier and a bit-serial exact divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | signals                     | beat contents
//  ---------+-----------------------------+------------------------------
//  request  | req_valid, req_stall, req   | cmd, set_size, pick_count
//  response | rsp_valid, rsp_stall, rsp   | count, status
//
// One request is worked at a time; req_stall is high from acceptance until
// the result has moved into the response register.
// A rejected request goes from idle straight to the completion state.
// Each product factor passes the multiply and check states; each binomial
// factor also passes the one-bit-a-cycle exact divider between the two.
// Work stops at the first product that no longer fits.
// A stalled response holds the finished count.
// Reset clears the sequencer and the response valid flag.
module combinatorial_count_unit #(
	parameter int MAX_N        = ccu_pkg::MAX_N_DEF,
	parameter int RESULT_WIDTH = ccu_pkg::RESULT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ccu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ccu_pkg::rsp_t rsp
);

	localparam int FW = ccu_pkg::FAC_W;
	localparam int PW = RESULT_WIDTH + FW;
	localparam int BW = $clog2(PW);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_CHK, S_DONE} state_t;
	typedef enum logic [1:0] {OP_HOLD, OP_DOWN, OP_UP, OP_BINOM} op_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [RESULT_WIDTH-1:0] acc_q;
	logic [PW-1:0]           prod_q;
	logic [FW-1:0]           fac_q;
	logic [FW-1:0]           cnt_q;
	logic [FW-1:0]           div_q;
	logic [FW-1:0]           rem_q;
	logic [BW-1:0]           bit_q;
	logic [1:0]              status_q;
	logic                    rsp_valid_q;
	ccu_pkg::rsp_t           rsp_q;

	logic [FW-1:0]             n9, k9, m9, mr9, r9;
	logic                      cmd_known, n_ok, k_ok, order_ok, req_ok;
	logic [PW-1:0]             prod_d;
	logic [FW:0]               trial, diff;
	logic                      q_bit;
	logic [ccu_pkg::COUNT_W-1:0] sat_count;

	assign sat_count = ccu_pkg::COUNT_W'({RESULT_WIDTH{1'b1}});

	// Operand checks and loop setup for the incoming request.
	always_comb begin
		n9 = FW'(req.set_size);
		k9 = FW'(req.pick_count);
		cmd_known = (req.cmd == ccu_pkg::CMD_POWER) || (req.cmd == ccu_pkg::CMD_ARRANGE) ||
			(req.cmd == ccu_pkg::CMD_MULTISET) || (req.cmd == ccu_pkg::CMD_COMBINE) ||
			(req.cmd == ccu_pkg::CMD_FACTORIAL);
		n_ok = (req.set_size != '0) && (32'(req.set_size) <= 32'(MAX_N));
		k_ok = (req.cmd == ccu_pkg::CMD_FACTORIAL) ||
			((req.pick_count != '0) && (32'(req.pick_count) <= 32'(MAX_N)));
		order_ok = !(((req.cmd == ccu_pkg::CMD_ARRANGE) || (req.cmd == ccu_pkg::CMD_COMBINE)) &&
			(req.pick_count > req.set_size));
		req_ok = cmd_known && n_ok && k_ok && order_ok;
		m9 = (req.cmd == ccu_pkg::CMD_MULTISET) ? FW'(n9 + k9 - FW'(1)) : n9;
		mr9 = m9 - k9;
		r9 = (k9 > mr9) ? mr9 : k9;
	end

	assign prod_d = PW'(acc_q) * PW'(fac_q);

	// One restoring step of the exact divide by the running index.
	always_comb begin
		trial = {rem_q, prod_q[PW-1]};
		diff = trial - {1'b0, div_q};
		q_bit = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_HOLD;
			acc_q <= '0;
			prod_q <= '0;
			fac_q <= '0;
			cnt_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			status_q <= ccu_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			// The completion state owns the valid flag while it is active.
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						acc_q <= RESULT_WIDTH'(1);
						div_q <= FW'(1);
						status_q <= req_ok ? ccu_pkg::ST_OK : ccu_pkg::ST_INVALID;
						case (req.cmd)
							ccu_pkg::CMD_POWER: begin
								op_q <= OP_HOLD;
								fac_q <= n9;
								cnt_q <= k9;
							end
							ccu_pkg::CMD_ARRANGE: begin
								op_q <= OP_DOWN;
								fac_q <= n9;
								cnt_q <= k9;
							end
							ccu_pkg::CMD_FACTORIAL: begin
								op_q <= OP_UP;
								fac_q <= FW'(2);
								cnt_q <= n9 - FW'(1);
							end
							default: begin
								op_q <= OP_BINOM;
								fac_q <= m9 - r9 + FW'(1);
								cnt_q <= r9;
							end
						endcase
						state_q <= req_ok ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						prod_q <= prod_d;
						rem_q <= '0;
						bit_q <= BW'(PW - 1);
						state_q <= (op_q == OP_BINOM) ? S_DIV : S_CHK;
					end
				end
				S_DIV: begin
					rem_q <= q_bit ? diff[FW-1:0] : trial[FW-1:0];
					prod_q <= {prod_q[PW-2:0], q_bit};
					if (bit_q == '0) begin
						state_q <= S_CHK;
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
				S_CHK: begin
					if (prod_q[PW-1:RESULT_WIDTH] != '0) begin
						status_q <= ccu_pkg::ST_OVERFLOW;
						state_q <= S_DONE;
					end else begin
						acc_q <= prod_q[RESULT_WIDTH-1:0];
						cnt_q <= cnt_q - FW'(1);
						div_q <= div_q + FW'(1);
						case (op_q)
							OP_DOWN: fac_q <= fac_q - FW'(1);
							OP_HOLD: fac_q <= fac_q;
							default: fac_q <= fac_q + FW'(1);
						endcase
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= status_q;
						case (status_q)
							ccu_pkg::ST_OK:       rsp_q.count <= ccu_pkg::COUNT_W'(acc_q);
							ccu_pkg::ST_OVERFLOW: rsp_q.count <= sat_count;
							default:              rsp_q.count <= '0;
						endcase
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ccu_pkg::ST_INVALID) |-> rsp.count == '0)
		else $error("invalid response carries a nonzero count");

	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ccu_pkg::ST_OVERFLOW) |-> rsp.count == sat_count)
		else $error("overflow response is not saturated");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != '0) && (rem_q < div_q))
		else $error("divider remainder out of range");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) && ($past(state_q) == S_DIV) |-> $past(bit_q) == '0)
		else $error("divide left before all quotient bits were formed");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == S_DONE)
		else $error("response raised outside the completion state");

endmodule
